// File: sv/glyph_atlas_shelf_packer_defines.svh
// assertion macros for the glyph atlas shelf packer
// used by the top level only, no other dependencies
`ifndef GLYPH_ATLAS_SHELF_PACKER_DEFINES_SVH
`define GLYPH_ATLAS_SHELF_PACKER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GASP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled in reset
`define GASP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: sv/gasp_pkg.sv
// shared types and constants for the glyph atlas shelf packer
// no dependencies
`default_nettype none

package gasp_pkg;

   localparam int unsigned MaxPages   = 256;
   localparam int unsigned WidthCap   = 8192;
   localparam int unsigned HeightCap  = 4096;
   localparam int unsigned LimitReset = 2048;
   localparam int unsigned PadReset   = 2;
   localparam int unsigned StartWReset = 128;
   localparam int unsigned StartHReset = 128;

   typedef enum logic [2:0] {
      ST_PLACED  = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_GROWN   = 3'd2,
      ST_NO_ROOM = 3'd3,
      ST_RESTART = 3'd4
   } status_type;

   typedef enum logic {
      FUNC_PLACE   = 1'b0,
      FUNC_RESTART = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      CSR_SIZE_LIMIT   = 2'd0,
      CSR_PADDING      = 2'd1,
      CSR_START_WIDTH  = 2'd2,
      CSR_START_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [14:0] size_limit;
      logic [3:0]  padding;
      logic [13:0] start_width;
      logic [12:0] start_height;
   } cfg_type;

   typedef struct packed {
      logic [13:0] cursor_x;
      logic [12:0] cursor_y;
      logic [13:0] row_height;
      logic [13:0] cur_width;
      logic [12:0] cur_height;
      logic [7:0]  page_index;
   } state_type;

   typedef struct packed {
      logic        func;
      logic [12:0] glyph_width;
      logic [12:0] glyph_height;
   } item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        new_page;
      logic [12:0] place_x;
      logic [11:0] place_y;
      logic [7:0]  page;
      logic [13:0] atlas_width;
      logic [12:0] atlas_height;
   } result_type;

endpackage

`default_nettype wire

// File: sv/gasp_place.sv
// placement logic: next packer state and result for one glyph item
// depends on gasp_pkg
`default_nettype none

module gasp_place (
   input  gasp_pkg::cfg_type    cfg,
   input  gasp_pkg::state_type  cur,
   input  gasp_pkg::item_type   item,
   output gasp_pkg::state_type  nxt,
   output gasp_pkg::result_type res
);

   logic [3:0]  p;
   logic [12:0] w;
   logic [12:0] h;
   logic [14:0] maxw;
   logic [14:0] maxh;
   logic [14:0] w2;
   logic [13:0] h2;
   logic        sq;
   logic        can_grow;
   logic [13:0] grow_w;
   logic [12:0] grow_h;
   logic [14:0] w_need;
   logic [14:0] h_need;
   logic        fits;
   logic [14:0] x_end;
   logic        wrap;
   logic [13:0] x_sel;
   logic [14:0] y_sel;
   logic [13:0] rh_sel;
   logic [15:0] y_end;
   logic        over_y;
   logic        page_full;
   logic [13:0] x_fin;
   logic [12:0] y_fin;
   logic [13:0] rh_fin;
   logic [13:0] x_next;
   logic [13:0] hp;
   gasp_pkg::state_type cleared;

   always_comb begin
      p = cfg.padding;
      w = item.glyph_width;
      h = item.glyph_height;

      maxw = (cfg.size_limit < 15'(gasp_pkg::WidthCap)) ? cfg.size_limit
                                                         : 15'(gasp_pkg::WidthCap);
      maxh = (cfg.size_limit < 15'(gasp_pkg::HeightCap)) ? cfg.size_limit
                                                          : 15'(gasp_pkg::HeightCap);
      w2 = {cur.cur_width, 1'b0};
      h2 = {cur.cur_height, 1'b0};
      sq = (cur.cur_width == {1'b0, cur.cur_height});
      if (sq) begin
         can_grow = (w2 > {1'b0, cur.cur_width}) && (w2 <= maxw);
      end else begin
         can_grow = (h2 > {1'b0, cur.cur_height}) && ({1'b0, h2} <= maxh);
      end
      grow_w = sq ? w2[13:0] : cur.cur_width;
      grow_h = sq ? cur.cur_height : h2[12:0];

      w_need = {2'b0, w} + {10'b0, p, 1'b0};
      h_need = {2'b0, h} + {10'b0, p, 1'b0};
      fits   = (w_need < {1'b0, cur.cur_width}) && (h_need < {2'b0, cur.cur_height});

      // new row when the glyph runs past the right edge
      x_end  = {1'b0, cur.cursor_x} + {2'b0, w} + {11'b0, p};
      wrap   = x_end > {1'b0, cur.cur_width};
      x_sel  = wrap ? {10'b0, p} : cur.cursor_x;
      y_sel  = wrap ? ({2'b0, cur.cursor_y} + {1'b0, cur.row_height})
                    : {2'b0, cur.cursor_y};
      rh_sel = wrap ? {10'b0, p} : cur.row_height;

      // atlas full below the last row
      y_end     = {1'b0, y_sel} + {3'b0, h} + {12'b0, p};
      over_y    = y_end > {3'b0, cur.cur_height};
      page_full = ({1'b0, cur.page_index} + 9'd1) >= 9'(gasp_pkg::MaxPages);

      x_fin  = over_y ? {10'b0, p} : x_sel;
      y_fin  = over_y ? {9'b0, p} : y_sel[12:0];
      rh_fin = over_y ? {10'b0, p} : rh_sel;
      x_next = x_fin + {1'b0, w} + {10'b0, p};
      hp     = {1'b0, h} + {10'b0, p};

      cleared.cursor_x   = {10'b0, p};
      cleared.cursor_y   = {9'b0, p};
      cleared.row_height = {10'b0, p};
      cleared.cur_width  = cur.cur_width;
      cleared.cur_height = cur.cur_height;
      cleared.page_index = '0;

      nxt          = cur;
      res.status   = gasp_pkg::ST_PLACED;
      res.new_page = 1'b0;
      res.place_x  = '0;
      res.place_y  = '0;

      if (item.func == gasp_pkg::FUNC_RESTART) begin
         nxt            = cleared;
         nxt.cur_width  = cfg.start_width;
         nxt.cur_height = cfg.start_height;
         res.status     = gasp_pkg::ST_RESTART;
      end else if (w == 13'd0 || h == 13'd0) begin
         res.status = gasp_pkg::ST_EMPTY;
      end else if (fits && !(over_y && (can_grow || page_full))) begin
         nxt.cursor_x   = x_next;
         nxt.cursor_y   = y_fin;
         nxt.row_height = (rh_fin > hp) ? rh_fin : hp;
         if (over_y) begin
            nxt.page_index = cur.page_index + 8'd1;
         end
         res.new_page = over_y;
         res.place_x  = x_fin[12:0];
         res.place_y  = y_fin[11:0];
      end else if (can_grow) begin
         nxt            = cleared;
         nxt.cur_width  = grow_w;
         nxt.cur_height = grow_h;
         res.status     = gasp_pkg::ST_GROWN;
      end else begin
         res.status = gasp_pkg::ST_NO_ROOM;
      end

      res.page         = nxt.page_index;
      res.atlas_width  = nxt.cur_width;
      res.atlas_height = nxt.cur_height;
   end

endmodule

`default_nettype wire

// File: sv/glyph_atlas_shelf_packer.sv
// glyph atlas shelf packer: request held in the input register, result registered in the output register
// throughput one item per cycle unless the result stalls; a stalled result holds the input register and stalls req
// the packer state loop runs from the state register through gasp_place back into it
// reset: cfg, state and valid registers to their reset values, atlas at start size, page 0, no clearing pass
// depends on gasp_pkg, gasp_place and glyph_atlas_shelf_packer_defines.svh
`default_nettype none
`include "glyph_atlas_shelf_packer_defines.svh"

module glyph_atlas_shelf_packer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_func,
   input  wire logic [12:0] req_glyph_width,
   input  wire logic [12:0] req_glyph_height,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [2:0]  rsp_status,
   output      logic        rsp_new_page,
   output      logic [12:0] rsp_place_x,
   output      logic [11:0] rsp_place_y,
   output      logic [7:0]  rsp_page,
   output      logic [13:0] rsp_atlas_width,
   output      logic [12:0] rsp_atlas_height,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_data
);

   gasp_pkg::cfg_type    cfg_ff, cfg_in;
   gasp_pkg::state_type  state_ff, state_in;
   gasp_pkg::state_type  state_calc;
   gasp_pkg::item_type   item_ff;
   gasp_pkg::result_type res_ff, res_calc;
   logic                 in_vld_ff, in_vld_in;
   logic                 out_vld_ff, out_vld_in;
   logic                 fire;
   logic                 req_take;
   logic                 st_placed;
   logic                 st_cleared;
   logic                 at_origin;

   assign fire      = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !fire;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   gasp_place u_place (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_calc),
      .res  (res_calc)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (gasp_pkg::csr_index_type'(csr_index))
            gasp_pkg::CSR_SIZE_LIMIT:   cfg_in.size_limit   = csr_data;
            gasp_pkg::CSR_PADDING:      cfg_in.padding      = csr_data[3:0];
            gasp_pkg::CSR_START_WIDTH:  cfg_in.start_width  = csr_data[13:0];
            gasp_pkg::CSR_START_HEIGHT: cfg_in.start_height = csr_data[12:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in   = fire ? state_calc : state_ff;
      in_vld_in  = req_stall ? in_vld_ff : req_valid;
      out_vld_in = fire ? 1'b1 : (out_vld_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_limit   <= 15'(gasp_pkg::LimitReset);
         cfg_ff.padding      <= 4'(gasp_pkg::PadReset);
         cfg_ff.start_width  <= 14'(gasp_pkg::StartWReset);
         cfg_ff.start_height <= 13'(gasp_pkg::StartHReset);
         state_ff.cursor_x   <= 14'(gasp_pkg::PadReset);
         state_ff.cursor_y   <= 13'(gasp_pkg::PadReset);
         state_ff.row_height <= 14'(gasp_pkg::PadReset);
         state_ff.cur_width  <= 14'(gasp_pkg::StartWReset);
         state_ff.cur_height <= 13'(gasp_pkg::StartHReset);
         state_ff.page_index <= '0;
         in_vld_ff           <= 1'b0;
         out_vld_ff          <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         state_ff   <= state_in;
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.func         <= req_func;
         item_ff.glyph_width  <= req_glyph_width;
         item_ff.glyph_height <= req_glyph_height;
      end
      if (fire) begin
         res_ff <= res_calc;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_status       = res_ff.status;
   assign rsp_new_page     = res_ff.new_page;
   assign rsp_place_x      = res_ff.place_x;
   assign rsp_place_y      = res_ff.place_y;
   assign rsp_page         = res_ff.page;
   assign rsp_atlas_width  = res_ff.atlas_width;
   assign rsp_atlas_height = res_ff.atlas_height;

   assign st_placed  = rsp_status == gasp_pkg::ST_PLACED;
   assign st_cleared = rsp_status == gasp_pkg::ST_GROWN || rsp_status == gasp_pkg::ST_RESTART;
   assign at_origin  = rsp_page == 8'd0 && rsp_place_x == 13'd0 && rsp_place_y == 12'd0;

   `GASP_ASSERT_NOW(a_new_page_placed, clock, reset, rsp_valid && rsp_new_page, st_placed)
   `GASP_ASSERT_NOW(a_clear_page_zero, clock, reset, rsp_valid && st_cleared, at_origin)
   `GASP_ASSERT_NEXT(a_item_held, clock, reset, in_vld_ff && out_vld_ff && rsp_stall, in_vld_ff)

endmodule

`default_nettype wire

// File: verif/glyph_atlas_shelf_packer_tb.sv
// self-checking testbench for glyph_atlas_shelf_packer: random glyph streams, restarts and
// register settings, each result checked against a shelf packing predictor kept in the bench
// depends on gasp_pkg and the glyph_atlas_shelf_packer rtl
`default_nettype none

module glyph_atlas_shelf_packer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [12:0] req_glyph_width = '0;
   logic [12:0] req_glyph_height = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_new_page;
   logic [12:0] rsp_place_x;
   logic [11:0] rsp_place_y;
   logic [7:0]  rsp_page;
   logic [13:0] rsp_atlas_width;
   logic [12:0] rsp_atlas_height;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [14:0] csr_data = '0;

   gasp_pkg::item_type   pending_glyphs[$];
   gasp_pkg::result_type expected_placements[$];
   gasp_pkg::result_type want;
   gasp_pkg::item_type   next_glyph;
   gasp_pkg::cfg_type    regs;
   gasp_pkg::state_type  shelf;

   int  errors = 0;
   int  queued = 0;
   int  answered = 0;
   int  idle_cycles = 0;
   int  send_gap = 0;
   int  glyphs_sent = 0;
   int  hold_left = 0;
   int  stall_cycles = 0;
   bit  req_took = 1'b0;
   bit  send_calm = 1'b0;
   bit  recv_calm = 1'b0;

   glyph_atlas_shelf_packer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_glyph_width  (req_glyph_width),
      .req_glyph_height (req_glyph_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_new_page     (rsp_new_page),
      .rsp_place_x      (rsp_place_x),
      .rsp_place_y      (rsp_place_y),
      .rsp_page         (rsp_page),
      .rsp_atlas_width  (rsp_atlas_width),
      .rsp_atlas_height (rsp_atlas_height),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #4ns clock = ~clock;

   function automatic gasp_pkg::item_type glyph(gasp_pkg::func_type f, logic [12:0] w,
                                                logic [12:0] h);
      gasp_pkg::item_type g;
      g.func = f;
      g.glyph_width = w;
      g.glyph_height = h;
      return g;
   endfunction

   function automatic int pick_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // next atlas size when the current one overflows
   function automatic bit next_atlas(output int unsigned nw, output int unsigned nh);
      int unsigned maxw, maxh, w, h, lim;
      lim = 32'(regs.size_limit);
      maxw = lim < gasp_pkg::WidthCap ? lim : gasp_pkg::WidthCap;
      maxh = lim < gasp_pkg::HeightCap ? lim : gasp_pkg::HeightCap;
      w = 32'(shelf.cur_width);
      h = 32'(shelf.cur_height);
      nw = w;
      nh = h;
      if (w * 2 <= maxw || h * 2 <= maxh) begin
         if (w == h) begin
            if (w * 2 > w && w * 2 <= maxw) begin
               nw = w * 2;
               return 1'b1;
            end
         end else if (h * 2 > h && h * 2 <= maxh) begin
            nh = h * 2;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic gasp_pkg::result_type pack_glyph(gasp_pkg::item_type g);
      int unsigned          p, w, h, x, y, rh, nw, nh;
      bit                   fits, spill, fresh;
      gasp_pkg::status_type outcome;
      gasp_pkg::result_type res;
      p = 32'(regs.padding);
      w = 32'(g.glyph_width);
      h = 32'(g.glyph_height);
      x = 0;
      y = 0;
      fresh = 1'b0;
      outcome = gasp_pkg::ST_PLACED;
      if (g.func == gasp_pkg::FUNC_RESTART) begin
         shelf.cur_width = regs.start_width;
         shelf.cur_height = regs.start_height;
         shelf.page_index = '0;
         shelf.cursor_x = 14'(p);
         shelf.cursor_y = 13'(p);
         shelf.row_height = 14'(p);
         outcome = gasp_pkg::ST_RESTART;
      end else if (w == 0 || h == 0) begin
         outcome = gasp_pkg::ST_EMPTY;
      end else begin
         x = 32'(shelf.cursor_x);
         y = 32'(shelf.cursor_y);
         rh = 32'(shelf.row_height);
         fits = w + 2 * p < 32'(shelf.cur_width) && h + 2 * p < 32'(shelf.cur_height);
         spill = 1'b0;
         if (fits) begin
            if (x + w + p > 32'(shelf.cur_width)) begin
               x = p;
               y = y + rh;
               rh = p;
            end
            spill = y + h + p > 32'(shelf.cur_height);
         end
         if (!fits || spill) begin
            if (next_atlas(nw, nh)) begin
               shelf.cur_width = 14'(nw);
               shelf.cur_height = 13'(nh);
               shelf.page_index = '0;
               shelf.cursor_x = 14'(p);
               shelf.cursor_y = 13'(p);
               shelf.row_height = 14'(p);
               outcome = gasp_pkg::ST_GROWN;
            end else if (!fits || 32'(shelf.page_index) + 1 >= gasp_pkg::MaxPages) begin
               outcome = gasp_pkg::ST_NO_ROOM;
            end else begin
               shelf.page_index = shelf.page_index + 8'd1;
               x = p;
               y = p;
               rh = p;
               fresh = 1'b1;
            end
         end
         if (outcome == gasp_pkg::ST_PLACED) begin
            shelf.cursor_x = 14'(x + w + p);
            shelf.cursor_y = 13'(y);
            shelf.row_height = 14'(rh > h + p ? rh : h + p);
         end
      end
      res.status = outcome;
      res.new_page = outcome == gasp_pkg::ST_PLACED ? fresh : 1'b0;
      res.place_x = outcome == gasp_pkg::ST_PLACED ? 13'(x) : 13'd0;
      res.place_y = outcome == gasp_pkg::ST_PLACED ? 12'(y) : 12'd0;
      res.page = shelf.page_index;
      res.atlas_width = shelf.cur_width;
      res.atlas_height = shelf.cur_height;
      return res;
   endfunction

   function automatic gasp_pkg::item_type make_glyph();
      gasp_pkg::item_type g;
      int                 pick, sel;
      pick = $urandom_range(0, 99);
      g = glyph(gasp_pkg::FUNC_PLACE, 13'($urandom_range(1, 48)), 13'($urandom_range(1, 48)));
      if (pick < 3) begin
         g = glyph(gasp_pkg::FUNC_RESTART, 13'($urandom), 13'($urandom));
      end else if (pick < 8) begin
         sel = $urandom_range(0, 2);
         g.glyph_width = sel != 1 ? 13'd0 : 13'($urandom);
         g.glyph_height = sel != 0 ? 13'd0 : 13'($urandom);
      end else if (pick < 25) begin
         g.glyph_width = 13'($urandom_range(1, 400));
         g.glyph_height = 13'($urandom_range(1, 400));
      end else if (pick < 32) begin
         g.glyph_width = 13'($urandom_range(1, 8191));
         g.glyph_height = 13'($urandom_range(1, 8191));
      end else if (pick < 36) begin
         g.glyph_width = 13'($urandom);
         g.glyph_height = 13'($urandom);
      end
      return g;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] got);
      if (got !== exp_val) begin
         errors++;
         if (errors <= 10)
            $display("mismatch on %s: expected %0d, got %0d", name, exp_val, got);
      end
   endfunction

   task automatic push_glyph(gasp_pkg::item_type g);
      pending_glyphs = {pending_glyphs, g};
      queued++;
   endtask

   // wait until all queued glyphs are answered, then let the pipeline drain
   task automatic settle();
      do @(negedge clock); while (answered != queued);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(gasp_pkg::csr_index_type idx, int unsigned val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[14:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(int unsigned lim, int unsigned pad, int unsigned sw, int unsigned sh);
      settle();
      write_reg(gasp_pkg::CSR_SIZE_LIMIT, lim);
      write_reg(gasp_pkg::CSR_PADDING, pad);
      write_reg(gasp_pkg::CSR_START_WIDTH, sw);
      write_reg(gasp_pkg::CSR_START_HEIGHT, sh);
   endtask

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_took)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_glyphs.size() > 0) begin
            next_glyph = pending_glyphs.pop_front();
            req_valid <= 1'b1;
            req_func <= next_glyph.func;
            req_glyph_width <= next_glyph.glyph_width;
            req_glyph_height <= next_glyph.glyph_height;
            glyphs_sent++;
            if (glyphs_sent % 64 == 0) send_calm = $urandom_range(0, 3) == 0;
            send_gap = pick_gap(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      stall_cycles++;
      if (stall_cycles % 128 == 0) recv_calm = $urandom_range(0, 3) == 0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!recv_calm && $urandom_range(0, 3) == 0) hold_left = pick_gap(1'b0);
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_took = 1'b0;
      end else begin
         req_took = req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_placements.size() == 0) begin
               errors++;
               if (errors <= 10) $display("result with nothing pending, status %0d", rsp_status);
            end else begin
               want = expected_placements.pop_front();
               answered++;
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("new_page", 32'(want.new_page), 32'(rsp_new_page));
               check_field("place_x", 32'(want.place_x), 32'(rsp_place_x));
               check_field("place_y", 32'(want.place_y), 32'(rsp_place_y));
               check_field("page", 32'(want.page), 32'(rsp_page));
               check_field("atlas_width", 32'(want.atlas_width), 32'(rsp_atlas_width));
               check_field("atlas_height", 32'(want.atlas_height), 32'(rsp_atlas_height));
            end
         end
         if (req_took)
            expected_placements = {expected_placements,
                                   pack_glyph(glyph(gasp_pkg::func_type'(req_func),
                                                    req_glyph_width, req_glyph_height))};
         if (csr_valid && csr_ready) begin
            case (gasp_pkg::csr_index_type'(csr_index))
               gasp_pkg::CSR_SIZE_LIMIT:   regs.size_limit = csr_data;
               gasp_pkg::CSR_PADDING:      regs.padding = csr_data[3:0];
               gasp_pkg::CSR_START_WIDTH:  regs.start_width = csr_data[13:0];
               gasp_pkg::CSR_START_HEIGHT: regs.start_height = csr_data[12:0];
               default: ;
            endcase
         end
         if (req_took || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      int unsigned lim, pad, sw, sh;
      regs.size_limit = 15'(gasp_pkg::LimitReset);
      regs.padding = 4'(gasp_pkg::PadReset);
      regs.start_width = 14'(gasp_pkg::StartWReset);
      regs.start_height = 13'(gasp_pkg::StartHReset);
      shelf.cursor_x = 14'(gasp_pkg::PadReset);
      shelf.cursor_y = 13'(gasp_pkg::PadReset);
      shelf.row_height = 14'(gasp_pkg::PadReset);
      shelf.cur_width = 14'(gasp_pkg::StartWReset);
      shelf.cur_height = 13'(gasp_pkg::StartHReset);
      shelf.page_index = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: empties, row wrap, growth up to the limit, new page
      push_glyph(glyph(gasp_pkg::FUNC_PLACE, 13'd1, 13'd1));
      push_glyph(glyph(gasp_pkg::FUNC_PLACE, 13'd0, 13'd5));
      push_glyph(glyph(gasp_pkg::FUNC_PLACE, 13'd5, 13'd0));
      push_glyph(glyph(gasp_pkg::FUNC_PLACE, 13'd0, 13'd0));
      push_glyph(glyph(gasp_pkg::FUNC_PLACE, 13'd123, 13'd10));
      push_glyph(glyph(gasp_pkg::FUNC_PLACE, 13'd1, 13'd115));
      push_glyph(glyph(gasp_pkg::FUNC_PLACE, 13'd124, 13'd10));
      push_glyph(glyph(gasp_pkg::FUNC_RESTART, 13'd8191, 13'd8191));
      push_glyph(glyph(gasp_pkg::FUNC_PLACE, 13'd124, 13'd1));
      repeat (10) push_glyph(glyph(gasp_pkg::FUNC_PLACE, 13'd8191, 13'd8191));
      push_glyph(glyph(gasp_pkg::FUNC_PLACE, 13'd4000, 13'd4000));
      push_glyph(glyph(gasp_pkg::FUNC_PLACE, 13'd2043, 13'd2043));
      push_glyph(glyph(gasp_pkg::FUNC_PLACE, 13'd1, 13'd2043));
      push_glyph(glyph(gasp_pkg::FUNC_RESTART, 13'd0, 13'd0));

      // largest atlas, no padding
      set_regs(16384, 0, 8192, 4096);
      push_glyph(glyph(gasp_pkg::FUNC_RESTART, 13'd0, 13'd0));
      repeat (200) push_glyph(make_glyph());

      // smallest atlas that cannot grow: every glyph after the first opens a page until pages run out
      set_regs(128, 15, 128, 128);
      push_glyph(glyph(gasp_pkg::FUNC_RESTART, 13'd0, 13'd0));
      repeat (262)
         push_glyph(glyph(gasp_pkg::FUNC_PLACE, 13'($urandom_range(60, 97)),
                          13'($urandom_range(60, 97))));
      push_glyph(glyph(gasp_pkg::FUNC_RESTART, 13'd0, 13'd0));

      repeat (5) begin
         lim = $urandom_range(128, 16384);
         pad = $urandom_range(0, 15);
         sw = 128 << $urandom_range(0, 6);
         sh = 128 << $urandom_range(0, 5);
         set_regs(lim, pad, sw, sh);
         if ($urandom_range(0, 3) != 0) push_glyph(glyph(gasp_pkg::FUNC_RESTART, 13'd0, 13'd0));
         repeat (190) push_glyph(make_glyph());
      end

      settle();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
